/* hw/rtl/fcsu_pkg.sv */
package fcsu_pkg;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_FRAME = 2'd1;
	localparam logic [1:0] ACT_WRITE = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;

	localparam logic [4:0] REG_SWEEP   = 5'd0;
	localparam logic [4:0] REG_P1_DUTY = 5'd1;
	localparam logic [4:0] REG_P1_ENV  = 5'd2;
	localparam logic [4:0] REG_P1_FLO  = 5'd3;
	localparam logic [4:0] REG_P1_CTL  = 5'd4;
	localparam logic [4:0] REG_P2_DUTY = 5'd6;
	localparam logic [4:0] REG_P2_ENV  = 5'd7;
	localparam logic [4:0] REG_P2_FLO  = 5'd8;
	localparam logic [4:0] REG_P2_CTL  = 5'd9;
	localparam logic [4:0] REG_W_DAC   = 5'd10;
	localparam logic [4:0] REG_W_LEN   = 5'd11;
	localparam logic [4:0] REG_W_VOL   = 5'd12;
	localparam logic [4:0] REG_W_FLO   = 5'd13;
	localparam logic [4:0] REG_W_CTL   = 5'd14;
	localparam logic [4:0] REG_N_LEN   = 5'd16;
	localparam logic [4:0] REG_N_ENV   = 5'd17;
	localparam logic [4:0] REG_N_POLY  = 5'd18;
	localparam logic [4:0] REG_N_CTL   = 5'd19;
	localparam logic [4:0] REG_VOL     = 5'd20;
	localparam logic [4:0] REG_PAN     = 5'd21;
	localparam logic [4:0] REG_POWER   = 5'd22;

	localparam logic [14:0] NOISE_SEED = 15'h7FFF;
	localparam logic [11:0] FREQ_MAX   = 12'd2047;

	// Bit n of a row is the output of the duty pattern at step n.
	localparam logic [3:0][7:0] DUTY_TABLE = '{8'b0111_1110, 8'b1110_0001,
		8'b1000_0001, 8'b1000_0000};

	typedef struct packed {
		logic [1:0] action;
		logic [5:0] reg_offset;
		logic [7:0] write_data;
	} item_t;

	typedef struct packed {
		logic       power_on;
		logic [3:0] channels_on;
		logic [3:0] noise_level;
		logic [3:0] wave_level;
		logic [3:0] pulse2_level;
		logic [3:0] pulse1_level;
		logic [7:0] read_data;
	} result_t;

	typedef struct packed {
		logic [22:0][7:0] regs;
		logic [15:0][7:0] wave;
		logic             powered;
		logic [3:0]       en;
		logic [3:0]       dac;
		logic [3:0]       lon;
		logic [3:0][8:0]  len;
		logic [1:0][13:0] ptmr;
		logic [1:0][2:0]  dpos;
		logic [2:0][3:0]  evol;
		logic [2:0][3:0]  etmr;
		logic [2:0]       erun;
		logic [2:0]       elock;
		logic [11:0]      wtmr;
		logic [4:0]       wpos;
		logic [3:0]       wnib;
		logic             whalf;
		logic             wopen;
		logic [21:0]      ntmr;
		logic [14:0]      nshift;
		logic [10:0]      sshadow;
		logic [3:0]       scnt;
		logic             sact;
		logic             ssub;
		logic [2:0]       seq;
	} state_t;

endpackage

/* hw/rtl/fcsu_core.sv */
module fcsu_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            exec,
	input  fcsu_pkg::item_t item,
	input  logic            newer,
	output fcsu_pkg::result_t res
);
	import fcsu_pkg::*;

	state_t st_q;
	state_t st_d;

	function automatic state_t reset_state();
		state_t c;
		c = '0;
		c.nshift = NOISE_SEED;
		return c;
	endfunction

	function automatic logic [4:0] env_reg(input logic [1:0] e);
		logic [4:0] r;
		unique case (e)
			2'd0: r = REG_P1_ENV;
			2'd1: r = REG_P2_ENV;
			default: r = REG_N_ENV;
		endcase
		return r;
	endfunction

	function automatic logic [13:0] pulse_reload(input state_t s, input logic p);
		logic [10:0] f;
		logic [11:0] d;
		f = p ? {s.regs[REG_P2_CTL][2:0], s.regs[REG_P2_FLO]}
			: {s.regs[REG_P1_CTL][2:0], s.regs[REG_P1_FLO]};
		d = 12'd2048 - {1'b0, f};
		return {d, 2'b00};
	endfunction

	function automatic logic [11:0] wave_reload(input state_t s);
		return {1'b0, ~{s.regs[REG_W_CTL][2:0], s.regs[REG_W_FLO]}};
	endfunction

	function automatic logic [21:0] noise_reload(input state_t s);
		logic [2:0] code;
		logic [6:0] base;
		code = s.regs[REG_N_POLY][2:0];
		base = (code == 3'd0) ? 7'd8 : {code, 4'b0000};
		return 22'(base) << s.regs[REG_N_POLY][7:4];
	endfunction

	function automatic logic [11:0] sweep_calc(inout state_t s);
		logic [11:0] delta;
		logic [11:0] r;
		delta = {1'b0, s.sshadow} >> s.regs[REG_SWEEP][2:0];
		if (s.regs[REG_SWEEP][3]) begin
			s.ssub = 1'b1;
			r = {1'b0, s.sshadow} - delta;
		end else begin
			r = {1'b0, s.sshadow} + delta;
		end
		return r;
	endfunction

	function automatic void power_down(inout state_t s, input logic nm);
		state_t c;
		c = '0;
		c.wave = s.wave;
		c.len = nm ? '0 : s.len;
		c.nshift = NOISE_SEED;
		s = c;
	endfunction

	function automatic void env_trigger(inout state_t s, input logic [1:0] e);
		logic [7:0] r;
		r = s.regs[env_reg(e)];
		s.elock[e] = 1'b0;
		s.evol[e] = r[7:4];
		s.etmr[e] = (r[2:0] == 3'd0) ? 4'd8 : {1'b0, r[2:0]};
		s.erun[e] = r[2:0] != 3'd0;
		if (s.seq == 3'd7 && s.erun[e])
			s.etmr[e] = s.etmr[e] + 4'd1;
	endfunction

	function automatic void env_glitch(inout state_t s, input logic [1:0] e,
		input logic [7:0] v, input logic [7:0] old);
		logic tck;
		if (s.erun[e])
			s.etmr[e] = {1'b0, v[2:0]};
		tck = v[2:0] != 3'd0 && old[2:0] == 3'd0 && !s.elock[e];
		if (v[3:0] == 4'd8 && old[3:0] == 4'd8 && !s.elock[e])
			tck = 1'b1;
		if (v[3] != old[3]) begin
			if (v[3]) begin
				if (old[2:0] == 3'd0 && !s.elock[e])
					s.evol[e] = s.evol[e] ^ 4'hF;
				else
					s.evol[e] = 4'hE - s.evol[e];
				tck = 1'b0;
			end else begin
				s.evol[e] = 4'h0 - s.evol[e];
			end
		end
		if (tck) begin
			s.evol[e] = v[3] ? s.evol[e] + 4'd1 : s.evol[e] - 4'd1;
		end else if (v[2:0] == 3'd0 && s.erun[e]) begin
			s.erun[e] = 1'b0;
		end
	endfunction

	function automatic void length_reload(inout state_t s, input logic [1:0] ch,
		input logic [8:0] full);
		if (s.len[ch] == 9'd0)
			s.len[ch] = full - {8'd0, s.lon[ch] & s.seq[0]};
	endfunction

	function automatic void trigger(inout state_t s, input logic [1:0] ch, input logic nm);
		logic [2:0]  pace;
		logic [2:0]  shift;
		logic [3:0]  cur;
		logic [3:0]  src;
		logic [13:0] per;
		logic [11:0] f;
		if (ch[1] == 1'b0) begin
			s.en[ch] = s.dac[ch];
			length_reload(s, ch, 9'd64);
			per = pulse_reload(s, ch[0]);
			s.ptmr[ch[0]] = {per[13:2], s.ptmr[ch[0]][1:0]} + 14'd5;
			env_trigger(s, ch);
			if (ch == 2'd0) begin
				pace = s.regs[REG_SWEEP][6:4];
				shift = s.regs[REG_SWEEP][2:0];
				s.sshadow = {s.regs[REG_P1_CTL][2:0], s.regs[REG_P1_FLO]};
				s.scnt = (pace == 3'd0) ? 4'd8 : {1'b0, pace};
				s.sact = pace != 3'd0 || shift != 3'd0;
				s.ssub = 1'b0;
				if (shift != 3'd0) begin
					f = sweep_calc(s);
					if (f > FREQ_MAX)
						s.en[0] = 1'b0;
				end
			end
		end else if (ch == 2'd2) begin
			if (!nm && s.en[2] && s.wtmr == 12'd0) begin
				cur = 4'((s.wpos + 5'd1) >> 1);
				if (cur < 4'd4) begin
					s.wave[0] = s.wave[cur];
				end else begin
					src = {cur[3:2], 2'b00};
					for (int i = 0; i < 4; i++)
						s.wave[i] = s.wave[src + 4'(i)];
				end
			end
			s.en[2] = s.dac[2];
			length_reload(s, 2'd2, 9'd256);
			s.wtmr = wave_reload(s) + 12'd3;
			s.wpos = 5'd0;
			s.wopen = nm;
		end else begin
			s.en[3] = s.dac[3];
			length_reload(s, 2'd3, 9'd64);
			s.ntmr = noise_reload(s);
			s.nshift = NOISE_SEED;
			env_trigger(s, 2'd2);
		end
	endfunction

	function automatic void write_control(inout state_t s, input logic [1:0] ch,
		input logic [7:0] v, input logic nm);
		if (!s.lon[ch] && v[6] && s.seq[0] && s.len[ch] != 9'd0) begin
			s.len[ch] = s.len[ch] - 9'd1;
			if (s.len[ch] == 9'd0 && !v[7])
				s.en[ch] = 1'b0;
		end
		s.lon[ch] = v[6];
		if (v[7])
			trigger(s, ch, nm);
	endfunction

	function automatic void write_volume(inout state_t s, input logic [1:0] ch,
		input logic [1:0] e, input logic [7:0] v, input logic [7:0] old, input logic nm);
		s.dac[ch] = v[7:3] != 5'd0;
		if (!s.dac[ch])
			s.en[ch] = 1'b0;
		else if (nm && s.en[ch])
			env_glitch(s, e, v, old);
	endfunction

	function automatic void reg_write(inout state_t s, input logic [5:0] off,
		input logic [7:0] v, input logic nm);
		logic [7:0] old;
		logic [4:0] a;
		a = off[4:0];
		if (off[5:4] == 2'b10) begin
			if (!s.en[2])
				s.wave[off[3:0]] = v;
			else if (nm || s.wopen)
				s.wave[s.wpos[4:1]] = v;
		end else if (off <= 6'd22) begin
			if (a == REG_POWER) begin
				if (!v[7])
					power_down(s, nm);
				else if (!s.powered) begin
					s.powered = 1'b1;
					s.seq = 3'd0;
				end
			end else if (!s.powered) begin
				if (!nm) begin
					if (a == REG_P1_DUTY)
						s.len[0] = 9'd64 - {3'd0, v[5:0]};
					else if (a == REG_P2_DUTY)
						s.len[1] = 9'd64 - {3'd0, v[5:0]};
					else if (a == REG_W_LEN)
						s.len[2] = 9'd256 - {1'b0, v};
					else if (a == REG_N_LEN)
						s.len[3] = 9'd64 - {3'd0, v[5:0]};
				end
			end else begin
				old = s.regs[a];
				s.regs[a] = v;
				unique case (a)
					REG_SWEEP:
						if (old[3] && !v[3] && s.ssub)
							s.en[0] = 1'b0;
					REG_P1_DUTY: s.len[0] = 9'd64 - {3'd0, v[5:0]};
					REG_P1_ENV:  write_volume(s, 2'd0, 2'd0, v, old, nm);
					REG_P1_CTL:  write_control(s, 2'd0, v, nm);
					REG_P2_DUTY: s.len[1] = 9'd64 - {3'd0, v[5:0]};
					REG_P2_ENV:  write_volume(s, 2'd1, 2'd1, v, old, nm);
					REG_P2_CTL:  write_control(s, 2'd1, v, nm);
					REG_W_DAC: begin
						s.dac[2] = v[7];
						if (!v[7])
							s.en[2] = 1'b0;
					end
					REG_W_LEN:   s.len[2] = 9'd256 - {1'b0, v};
					REG_W_CTL:   write_control(s, 2'd2, v, nm);
					REG_N_LEN:   s.len[3] = 9'd64 - {3'd0, v[5:0]};
					REG_N_ENV:   write_volume(s, 2'd3, 2'd2, v, old, nm);
					REG_N_CTL:   write_control(s, 2'd3, v, nm);
					default: ;
				endcase
			end
		end
	endfunction

	function automatic logic [7:0] reg_read(input state_t s, input logic [5:0] off,
		input logic nm);
		logic [7:0] v;
		logic [7:0] r;
		v = s.regs[off[4:0]];
		if (off[5:4] == 2'b10) begin
			if (!s.en[2])
				r = s.wave[off[3:0]];
			else if (!nm && !s.wopen)
				r = 8'hFF;
			else
				r = s.wave[s.wpos[4:1]];
		end else if (off > 6'd22) begin
			r = 8'hFF;
		end else begin
			unique case (off[4:0])
				REG_SWEEP: r = v | 8'h80;
				REG_P1_DUTY, REG_P2_DUTY: r = v | 8'h3F;
				REG_P1_ENV, REG_P2_ENV, REG_N_ENV, REG_N_POLY, REG_VOL, REG_PAN: r = v;
				REG_P1_CTL, REG_P2_CTL, REG_W_CTL, REG_N_CTL: r = v | 8'hBF;
				REG_W_DAC: r = v | 8'h7F;
				REG_W_VOL: r = v | 8'h9F;
				REG_POWER: r = {s.powered, 3'b111, s.en};
				default: r = 8'hFF;
			endcase
		end
		return r;
	endfunction

	function automatic void env_step(inout state_t s, input logic [1:0] e);
		logic [7:0] r;
		r = s.regs[env_reg(e)];
		if (s.erun[e] && !s.elock[e] && s.etmr[e] != 4'd0) begin
			s.etmr[e] = s.etmr[e] - 4'd1;
			if (s.etmr[e] == 4'd0) begin
				s.etmr[e] = (r[2:0] == 3'd0) ? 4'd8 : {1'b0, r[2:0]};
				if (r[3] && s.evol[e] != 4'd15)
					s.evol[e] = s.evol[e] + 4'd1;
				else if (!r[3] && s.evol[e] != 4'd0)
					s.evol[e] = s.evol[e] - 4'd1;
				else begin
					s.erun[e] = 1'b0;
					s.elock[e] = 1'b1;
				end
			end
		end
	endfunction

	function automatic void sweep_step(inout state_t s);
		logic [2:0]  pace;
		logic [11:0] f;
		logic [11:0] g;
		pace = s.regs[REG_SWEEP][6:4];
		if (s.scnt != 4'd0)
			s.scnt = s.scnt - 4'd1;
		if (s.scnt == 4'd0) begin
			s.scnt = (pace == 3'd0) ? 4'd8 : {1'b0, pace};
			if (s.sact && pace != 3'd0) begin
				f = sweep_calc(s);
				if (f > FREQ_MAX) begin
					s.en[0] = 1'b0;
				end else if (s.regs[REG_SWEEP][2:0] != 3'd0) begin
					s.sshadow = f[10:0];
					s.regs[REG_P1_FLO] = f[7:0];
					s.regs[REG_P1_CTL][2:0] = f[10:8];
					g = sweep_calc(s);
					if (g > FREQ_MAX)
						s.en[0] = 1'b0;
				end
			end
		end
	endfunction

	function automatic void frame_step(inout state_t s);
		if (s.powered) begin
			if (!s.seq[0]) begin
				for (int i = 0; i < 4; i++) begin
					if (s.lon[i] && s.len[i] != 9'd0) begin
						s.len[i] = s.len[i] - 9'd1;
						if (s.len[i] == 9'd0)
							s.en[i] = 1'b0;
					end
				end
			end
			if (s.seq == 3'd2 || s.seq == 3'd6)
				sweep_step(s);
			if (s.seq == 3'd7) begin
				for (int e = 0; e < 3; e++)
					env_step(s, 2'(e));
			end
		end
		s.seq = s.seq + 3'd1;
	endfunction

	function automatic void tick(inout state_t s);
		logic [7:0]  b;
		logic        fb;
		for (int p = 0; p < 2; p++) begin
			if (s.en[p]) begin
				if (s.ptmr[p] != 14'd0)
					s.ptmr[p] = s.ptmr[p] - 14'd1;
				if (s.ptmr[p] == 14'd0) begin
					s.ptmr[p] = pulse_reload(s, 1'(p));
					s.dpos[p] = s.dpos[p] + 3'd1;
				end
			end
		end
		if (s.en[2]) begin
			s.whalf = ~s.whalf;
			if (!s.whalf) begin
				s.wopen = 1'b0;
				if (s.wtmr == 12'd0) begin
					s.wtmr = wave_reload(s);
					s.wpos = s.wpos + 5'd1;
					b = s.wave[s.wpos[4:1]];
					s.wnib = s.wpos[0] ? b[3:0] : b[7:4];
					s.wopen = 1'b1;
				end else begin
					s.wtmr = s.wtmr - 12'd1;
				end
			end
		end
		if (s.en[3] && s.regs[REG_N_POLY][7:4] < 4'd14) begin
			if (s.ntmr != 22'd0)
				s.ntmr = s.ntmr - 22'd1;
			if (s.ntmr == 22'd0) begin
				s.ntmr = noise_reload(s);
				fb = s.nshift[0] ^ s.nshift[1];
				s.nshift = {fb, s.nshift[14:1]};
				if (s.regs[REG_N_POLY][3])
					s.nshift[6] = fb;
			end
		end
	endfunction

	always_comb begin
		state_t     s;
		logic [7:0] rd;
		logic [1:0] lvl;
		logic [1:0] d0;
		logic [1:0] d1;
		s = st_q;
		rd = 8'd0;
		unique case (item.action)
			ACT_TICK:  tick(s);
			ACT_FRAME: frame_step(s);
			ACT_WRITE: reg_write(s, item.reg_offset, item.write_data, newer);
			default:   rd = reg_read(s, item.reg_offset, newer);
		endcase
		st_d = s;
		d0 = s.regs[REG_P1_DUTY][7:6];
		d1 = s.regs[REG_P2_DUTY][7:6];
		lvl = s.regs[REG_W_VOL][6:5];
		res.read_data = rd;
		res.pulse1_level = (s.en[0] && s.dac[0] && DUTY_TABLE[d0][s.dpos[0]]) ? s.evol[0] : 4'd0;
		res.pulse2_level = (s.en[1] && s.dac[1] && DUTY_TABLE[d1][s.dpos[1]]) ? s.evol[1] : 4'd0;
		res.wave_level = (s.en[2] && s.dac[2] && lvl != 2'd0) ? s.wnib >> (lvl - 2'd1) : 4'd0;
		res.noise_level = (s.en[3] && s.dac[3] && !s.nshift[0]) ? s.evol[2] : 4'd0;
		res.channels_on = s.en;
		res.power_on = s.powered;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= reset_state();
		end else if (exec) begin
			st_q <= st_d;
		end
	end

endmodule

/* hw/rtl/four_channel_sound_unit.sv */
// Four-channel sound generator: two pulse channels (the first with a frequency
// sweep), a wave channel playing 32 nibbles and a noise channel.
// Each input beat on the s_axis side is one command: a master clock tick, a
// frame sequencer step, a register or wave RAM write, or a register read.
// Every command returns exactly one output beat on the m_axis side with the
// read byte, the four channel levels, the channel enable bits and the power flag.
// The APB port holds one register, the newer model mode bit at address 0; the user
// must write it only while no command is in flight; the block does not enforce this.
// A command is registered at the edge where it is accepted and executed once the
// output register is free, when its result is loaded into the output register;
// one command is taken every cycle while the receiver does not stall.
// All channel state is updated by a single combinational pass between the
// command register and the state and result registers.
// When the receiver stalls, the result stays in the output register, one more
// command waits in the command register, and s_tready drops after that.
// Reset leaves the unit powered off with all registers and the wave RAM zero
// and the noise shift register at all ones.
module four_channel_sound_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// action [1:0], reg_offset [7:2], write_data [15:8]
	input  logic [15:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_data [7:0], pulse1_level [11:8], pulse2_level [15:12], wave_level [19:16],
	// noise_level [23:20], channels_on [27:24], power_on [28], zero [31:29]
	output logic [31:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import fcsu_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t res_d;
	result_t res_q;
	logic    valid_q;
	logic    newer_q;
	logic    exec;

	assign exec = valid_s1 && (!valid_q || m_tready);
	assign s_tready = !valid_s1 || exec;
	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? {31'd0, newer_q} : 32'd0;

	fcsu_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.exec  (exec),
		.item  (item_s1),
		.newer (newer_q),
		.res   (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newer_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == 3'd0) begin
			newer_q <= pwdata[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (exec)
				valid_q <= 1'b1;
			else if (m_tready)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			item_s1 <= '{action: s_tdata[1:0], reg_offset: s_tdata[7:2],
				write_data: s_tdata[15:8]};
		if (exec)
			res_q <= res_d;
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {3'd0, res_q};

endmodule

/* hw/rtl/fcsu_checker.sv */
module fcsu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Stalled output beat changed.");

	a_off_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[28] |-> m_tdata[27:24] == 4'd0)
		else $error("Channel enabled while powered off.");

	a_pulse_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[24] || m_tdata[11:8] == 4'd0)
		&& (m_tdata[25] || m_tdata[15:12] == 4'd0))
		else $error("Disabled pulse channel has a level.");

	a_other_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[26] || m_tdata[19:16] == 4'd0)
		&& (m_tdata[27] || m_tdata[23:20] == 4'd0))
		else $error("Disabled wave or noise channel has a level.");

endmodule

bind four_channel_sound_unit fcsu_checker u_fcsu_checker (.*);

/* tb/sound_checker.sv */
`timescale 1ns / 100ps

module sound_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          errors,
	output int          pending,
	output int          beats_checked,
	output int          reads_checked
);
	import fcsu_pkg::*;

	logic [31:0] expected_beats[$];

	bit       newer;
	bit [7:0] regs[23];
	bit [7:0] wram[16];
	bit       powered;
	bit       en[4], dac[4], lon[4];
	int       len[4];
	int       ptmr[2], dpos[2];
	int       evol[3], etmr[3];
	bit       erun[3], elock[3];
	int       wtmr, wpos, wnib;
	bit       whalf, wopen;
	int       ntmr, nshift;
	int       sshadow, scnt;
	bit       sact, ssub;
	int       seq;

	function automatic int env_addr(int e);
		return e == 0 ? REG_P1_ENV : (e == 1 ? REG_P2_ENV : REG_N_ENV);
	endfunction

	function automatic int duty_addr(int p);
		return p == 0 ? REG_P1_DUTY : REG_P2_DUTY;
	endfunction

	function automatic int pulse_reload(int p);
		int b;
		b = duty_addr(p);
		return (2048 - (regs[b+2] | ((regs[b+3] & 7) << 8))) * 4;
	endfunction

	function automatic int wave_reload();
		return 2047 - (regs[REG_W_FLO] | ((regs[REG_W_CTL] & 7) << 8));
	endfunction

	function automatic int noise_reload();
		int code;
		code = regs[REG_N_POLY] & 7;
		return (code == 0 ? 8 : code * 16) << (regs[REG_N_POLY] >> 4);
	endfunction

	function automatic int sweep_next();
		int delta;
		delta = sshadow >> (regs[REG_SWEEP] & 7);
		if (regs[REG_SWEEP] & 8) begin
			ssub = 1;
			return sshadow - delta;
		end
		return sshadow + delta;
	endfunction

	function automatic void power_down();
		powered = 0;
		for (int i = 0; i < 23; i++) regs[i] = 0;
		for (int i = 0; i < 4; i++) begin
			en[i] = 0; dac[i] = 0; lon[i] = 0;
			if (newer) len[i] = 0;
		end
		for (int i = 0; i < 2; i++) begin
			ptmr[i] = 0; dpos[i] = 0;
		end
		for (int i = 0; i < 3; i++) begin
			evol[i] = 0; etmr[i] = 0; erun[i] = 0; elock[i] = 0;
		end
		wtmr = 0; wpos = 0; wnib = 0; whalf = 0; wopen = 0;
		ntmr = 0; nshift = NOISE_SEED;
		sshadow = 0; scnt = 0; sact = 0; ssub = 0;
		seq = 0;
	endfunction

	function automatic void env_start(int e);
		int r, per;
		r = regs[env_addr(e)];
		per = r & 7;
		elock[e] = 0;
		evol[e] = r >> 4;
		etmr[e] = per == 0 ? 8 : per;
		erun[e] = per != 0;
		if (seq == 7 && erun[e]) etmr[e]++;
	endfunction

	function automatic void env_glitch(int e, int v, int old);
		bit bump, flip;
		if (erun[e]) etmr[e] = v & 7;
		bump = (v & 7) != 0 && (old & 7) == 0 && !elock[e];
		flip = ((v ^ old) & 8) != 0;
		if ((v & 15) == 8 && (old & 15) == 8 && !elock[e]) bump = 1;
		if (flip) begin
			if (v & 8) begin
				if ((old & 7) == 0 && !elock[e]) evol[e] = evol[e] ^ 15;
				else evol[e] = (14 - evol[e]) & 15;
				bump = 0;
			end else begin
				evol[e] = (16 - evol[e]) & 15;
			end
		end
		if (bump) begin
			if (v & 8) evol[e] = (evol[e] + 1) & 15;
			else evol[e] = (evol[e] + 15) & 15;
		end else if ((v & 7) == 0 && erun[e]) begin
			erun[e] = 0;
		end
	endfunction

	function automatic void length_reload(int ch, int full);
		if (len[ch] == 0) len[ch] = full - ((lon[ch] && (seq & 1)) ? 1 : 0);
	endfunction

	function automatic void trigger(int ch);
		int pace, shift, cur, src;
		if (ch < 2) begin
			en[ch] = dac[ch];
			length_reload(ch, 64);
			ptmr[ch] = ((ptmr[ch] & 3) | (pulse_reload(ch) & ~3)) + 5;
			env_start(ch);
			if (ch == 0) begin
				pace = (regs[REG_SWEEP] >> 4) & 7;
				shift = regs[REG_SWEEP] & 7;
				sshadow = regs[REG_P1_FLO] | ((regs[REG_P1_CTL] & 7) << 8);
				scnt = pace == 0 ? 8 : pace;
				sact = pace != 0 || shift != 0;
				ssub = 0;
				if (shift != 0 && sweep_next() > 2047) en[0] = 0;
			end
		end else if (ch == 2) begin
			if (!newer && en[2] && wtmr == 0) begin
				cur = ((wpos + 1) & 31) / 2;
				if (cur < 4) begin
					wram[0] = wram[cur];
				end else begin
					src = cur & ~3;
					for (int i = 0; i < 4; i++) wram[i] = wram[(src + i) & 15];
				end
			end
			en[2] = dac[2];
			length_reload(2, 256);
			wtmr = wave_reload() + 3;
			wpos = 0;
			wopen = newer;
		end else begin
			en[3] = dac[3];
			length_reload(3, 64);
			ntmr = noise_reload();
			nshift = NOISE_SEED;
			env_start(2);
		end
	endfunction

	function automatic void write_control(int ch, int v);
		if (!lon[ch] && (v & 8'h40) && (seq & 1) && len[ch] != 0) begin
			len[ch]--;
			if (len[ch] == 0 && !(v & 8'h80)) en[ch] = 0;
		end
		lon[ch] = (v >> 6) & 1;
		if (v & 8'h80) trigger(ch);
	endfunction

	function automatic void write_volume(int ch, int e, int v, int old);
		dac[ch] = (v & 8'hF8) != 0;
		if (!dac[ch]) en[ch] = 0;
		else if (newer && en[ch]) env_glitch(e, v, old);
	endfunction

	function automatic void reg_write(int off, int v);
		int old;
		if (off >= 32 && off < 48) begin
			if (!en[2]) wram[off-32] = v;
			else if (newer || wopen) wram[(wpos >> 1) & 15] = v;
			return;
		end
		if (off > 22) return;
		if (off == REG_POWER) begin
			if (!(v & 8'h80)) power_down();
			else if (!powered) begin
				powered = 1;
				seq = 0;
			end
			return;
		end
		if (!powered) begin
			if (newer) return;
			case (off)
				REG_P1_DUTY: len[0] = 64 - (v & 63);
				REG_P2_DUTY: len[1] = 64 - (v & 63);
				REG_W_LEN:   len[2] = 256 - v;
				REG_N_LEN:   len[3] = 64 - (v & 63);
				default: ;
			endcase
			return;
		end
		old = regs[off];
		regs[off] = v;
		case (off)
			REG_SWEEP: if ((old & 8) && !(v & 8) && ssub) en[0] = 0;
			REG_P1_DUTY: len[0] = 64 - (v & 63);
			REG_P1_ENV:  write_volume(0, 0, v, old);
			REG_P1_CTL:  write_control(0, v);
			REG_P2_DUTY: len[1] = 64 - (v & 63);
			REG_P2_ENV:  write_volume(1, 1, v, old);
			REG_P2_CTL:  write_control(1, v);
			REG_W_DAC: begin
				dac[2] = (v >> 7) & 1;
				if (!dac[2]) en[2] = 0;
			end
			REG_W_LEN:  len[2] = 256 - v;
			REG_W_CTL:  write_control(2, v);
			REG_N_LEN:  len[3] = 64 - (v & 63);
			REG_N_ENV:  write_volume(3, 2, v, old);
			REG_N_CTL:  write_control(3, v);
			default: ;
		endcase
	endfunction

	function automatic bit [7:0] reg_read(int off);
		bit [7:0] v;
		if (off >= 32 && off < 48) begin
			if (!en[2]) return wram[off-32];
			if (!newer && !wopen) return 8'hFF;
			return wram[(wpos >> 1) & 15];
		end
		if (off > 22) return 8'hFF;
		v = regs[off];
		case (off)
			REG_SWEEP: return v | 8'h80;
			REG_P1_DUTY, REG_P2_DUTY: return v | 8'h3F;
			REG_P1_ENV, REG_P2_ENV, REG_N_ENV, REG_N_POLY, REG_VOL, REG_PAN: return v;
			REG_P1_CTL, REG_P2_CTL, REG_W_CTL, REG_N_CTL: return v | 8'hBF;
			REG_W_DAC: return v | 8'h7F;
			REG_W_VOL: return v | 8'h9F;
			REG_POWER: return {powered, 3'b111, en[3], en[2], en[1], en[0]};
			default: return 8'hFF;
		endcase
	endfunction

	function automatic void env_step(int e);
		int r, per;
		r = regs[env_addr(e)];
		per = r & 7;
		if (!erun[e] || elock[e] || etmr[e] == 0) return;
		etmr[e]--;
		if (etmr[e] != 0) return;
		etmr[e] = per == 0 ? 8 : per;
		if ((r & 8) && evol[e] < 15) evol[e]++;
		else if (!(r & 8) && evol[e] > 0) evol[e]--;
		else begin
			erun[e] = 0;
			elock[e] = 1;
		end
	endfunction

	function automatic void sweep_step();
		int pace, f;
		pace = (regs[REG_SWEEP] >> 4) & 7;
		if (scnt > 0) scnt--;
		if (scnt != 0) return;
		scnt = pace == 0 ? 8 : pace;
		if (!sact || pace == 0) return;
		f = sweep_next();
		if (f > FREQ_MAX) begin
			en[0] = 0;
			return;
		end
		if ((regs[REG_SWEEP] & 7) == 0) return;
		sshadow = f;
		regs[REG_P1_FLO] = f & 8'hFF;
		regs[REG_P1_CTL] = (regs[REG_P1_CTL] & 8'hF8) | ((f >> 8) & 7);
		if (sweep_next() > FREQ_MAX) en[0] = 0;
	endfunction

	function automatic void frame_step();
		if (powered) begin
			if ((seq & 1) == 0) begin
				for (int i = 0; i < 4; i++)
					if (lon[i] && len[i] != 0) begin
						len[i]--;
						if (len[i] == 0) en[i] = 0;
					end
			end
			if (seq == 2 || seq == 6) sweep_step();
			if (seq == 7) for (int i = 0; i < 3; i++) env_step(i);
		end
		seq = (seq + 1) & 7;
	endfunction

	function automatic void master_tick();
		int b, fb;
		for (int p = 0; p < 2; p++) begin
			if (en[p]) begin
				if (ptmr[p] > 0) ptmr[p]--;
				if (ptmr[p] == 0) begin
					ptmr[p] = pulse_reload(p);
					dpos[p] = (dpos[p] + 1) & 7;
				end
			end
		end
		if (en[2]) begin
			whalf = !whalf;
			if (!whalf) begin
				wopen = 0;
				if (wtmr == 0) begin
					wtmr = wave_reload();
					wpos = (wpos + 1) & 31;
					b = wram[(wpos >> 1) & 15];
					wnib = (wpos & 1) ? (b & 15) : (b >> 4);
					wopen = 1;
				end else begin
					wtmr--;
				end
			end
		end
		if (en[3] && (regs[REG_N_POLY] >> 4) < 14) begin
			if (ntmr > 0) ntmr--;
			if (ntmr == 0) begin
				ntmr = noise_reload();
				fb = (nshift ^ (nshift >> 1)) & 1;
				nshift = (nshift >> 1) | (fb << 14);
				if (regs[REG_N_POLY] & 8) nshift = (nshift & ~(1 << 6)) | (fb << 6);
			end
		end
	endfunction

	function automatic bit [3:0] pulse_level(int p);
		bit [7:0] row;
		row = DUTY_TABLE[regs[duty_addr(p)] >> 6];
		return (en[p] && dac[p] && row[dpos[p]]) ? evol[p][3:0] : 4'd0;
	endfunction

	function automatic result_t apply_command(item_t it);
		result_t r;
		int lvl;
		r = '0;
		case (it.action)
			ACT_TICK:  master_tick();
			ACT_FRAME: frame_step();
			ACT_WRITE: reg_write(it.reg_offset, it.write_data);
			default:   r.read_data = reg_read(it.reg_offset);
		endcase
		lvl = (regs[REG_W_VOL] >> 5) & 3;
		if (en[2] && dac[2] && lvl != 0) r.wave_level = wnib >> (lvl - 1);
		r.pulse1_level = pulse_level(0);
		r.pulse2_level = pulse_level(1);
		r.noise_level = (en[3] && dac[3] && !(nshift & 1)) ? evol[2][3:0] : 4'd0;
		r.channels_on = {en[3], en[2], en[1], en[0]};
		r.power_on = powered;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		string fname;
		int lo, w;
		logic [31:0] want, got, nxt;
		if (!arst_n) begin
			newer = 0;
			for (int i = 0; i < 16; i++) wram[i] = 0;
			for (int i = 0; i < 4; i++) len[i] = 0;
			power_down();
			expected_beats.delete();
			errors = 0;
			beats_checked = 0;
			reads_checked = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == 3'd0) newer = pwdata[0];
			if (m_tvalid && m_tready) begin
				if (expected_beats.size() == 0) begin
					errors++;
					if (errors <= 10) $display("Unexpected output beat %h", m_tdata);
				end else begin
					want = expected_beats.pop_front();
					got = m_tdata;
					beats_checked++;
					for (int f = 0; f < 8; f++) begin
						case (f)
							0: begin fname = "read_data"; lo = 0; w = 8; end
							1: begin fname = "pulse1_level"; lo = 8; w = 4; end
							2: begin fname = "pulse2_level"; lo = 12; w = 4; end
							3: begin fname = "wave_level"; lo = 16; w = 4; end
							4: begin fname = "noise_level"; lo = 20; w = 4; end
							5: begin fname = "channels_on"; lo = 24; w = 4; end
							6: begin fname = "power_on"; lo = 28; w = 1; end
							default: begin fname = "padding"; lo = 29; w = 3; end
						endcase
						if (((want >> lo) & ((1 << w) - 1)) != ((got >> lo) & ((1 << w) - 1)))
						begin
							errors++;
							if (errors <= 10)
								$display("Mismatch in %s of beat %0d: expected %0h, got %0h",
									fname, beats_checked, (want >> lo) & ((1 << w) - 1),
									(got >> lo) & ((1 << w) - 1));
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tdata[1:0] == ACT_READ) reads_checked++;
				nxt = {3'b000,
					apply_command('{s_tdata[1:0], s_tdata[7:2], s_tdata[15:8]})};
				expected_beats = {expected_beats, nxt};
			end
		end
		pending = expected_beats.size();
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
	import fcsu_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1;
	logic [31:0] m_tdata;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int errors, pending, beats_checked, reads_checked;
	int commands_sent, cycles;
	bit gaps_on, stalls_on, hold_req;

	four_channel_sound_unit dut (.*);

	sound_checker checker_i (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 0;
				for (int n = 0; n < 120; n++) @(posedge clk);
				m_tready <= 1;
				hold_req = 0;
			end else if (stalls_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				m_tready <= 1;
			end
		end
	end

	task automatic send(logic [1:0] act, int off, int data);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {data[7:0], off[5:0], act};
		do @(posedge clk); while (!s_tready);
		commands_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 0;
		do @(posedge clk); while (pending != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_mode(bit v);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= 3'd0;
		pwdata <= {31'd0, v};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic directed();
		send(ACT_READ, REG_POWER, 0);
		send(ACT_WRITE, 25, 8'hFF);
		send(ACT_READ, 25, 0);
		send(ACT_READ, 63, 0);
		send(ACT_WRITE, REG_P1_DUTY, 8'h3F);
		send(ACT_WRITE, REG_POWER, 8'h80);
		send(ACT_WRITE, 32, 8'hA5);
		send(ACT_WRITE, 47, 8'h3C);
		send(ACT_READ, 32, 0);
		send(ACT_WRITE, REG_P1_DUTY, 8'hC0);
		send(ACT_WRITE, REG_P1_ENV, 8'hF8);
		send(ACT_WRITE, REG_SWEEP, 8'h7F);
		send(ACT_WRITE, REG_P1_FLO, 8'hFF);
		send(ACT_WRITE, REG_P1_CTL, 8'hC7);
		send(ACT_WRITE, REG_P1_ENV, 8'hF0);
		send(ACT_WRITE, REG_W_DAC, 8'h80);
		send(ACT_WRITE, REG_W_VOL, 8'h20);
		send(ACT_WRITE, REG_W_FLO, 8'hFE);
		send(ACT_WRITE, REG_W_CTL, 8'hC7);
		for (int i = 0; i < 6; i++) send(ACT_TICK, 0, 0);
		send(ACT_READ, 47, 0);
		send(ACT_WRITE, REG_N_ENV, 8'h0F);
		send(ACT_WRITE, REG_N_CTL, 8'h80);
		send(ACT_FRAME, 0, 0);
		send(ACT_READ, REG_POWER, 0);
		send(ACT_WRITE, REG_POWER, 8'h00);
		send(ACT_READ, REG_POWER, 0);
	endtask

	task automatic random_write();
		int off, data, k;
		k = $urandom_range(0, 99);
		data = $urandom_range(0, 255);
		if (k < 80) begin
			off = $urandom_range(0, 21);
			if (off == REG_P1_CTL || off == REG_P2_CTL || off == REG_W_CTL)
				data = data | 7;
			if (off == REG_W_FLO) data = data | 8'hE0;
			if (off == REG_N_POLY) data = data & 8'h3F;
		end else if (k < 88) begin
			off = REG_POWER;
			if ($urandom_range(0, 5) != 0) data = data | 8'h80;
		end else if (k < 95) begin
			off = $urandom_range(32, 47);
		end else begin
			off = $urandom_range(0, 1) ? $urandom_range(23, 31) : $urandom_range(48, 63);
		end
		send(ACT_WRITE, off, data);
	endtask

	task automatic random_command();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) send(ACT_TICK, $urandom_range(0, 63), $urandom_range(0, 255));
		else if (k < 75) send(ACT_FRAME, $urandom_range(0, 63), $urandom_range(0, 255));
		else if (k < 88) send(ACT_READ, $urandom_range(0, 63), $urandom_range(0, 255));
		else random_write();
	endtask

	task automatic play_channel();
		int ch, n;
		ch = $urandom_range(0, 3);
		if ($urandom_range(0, 3) != 0) send(ACT_WRITE, REG_POWER, 8'h80);
		case (ch)
			0, 1: begin
				if (ch == 0) send(ACT_WRITE, REG_SWEEP, $urandom_range(0, 127));
				send(ACT_WRITE, ch ? REG_P2_DUTY : REG_P1_DUTY, $urandom_range(0, 255));
				send(ACT_WRITE, ch ? REG_P2_ENV : REG_P1_ENV, $urandom_range(8, 255));
				send(ACT_WRITE, ch ? REG_P2_FLO : REG_P1_FLO, $urandom_range(0, 255));
				send(ACT_WRITE, ch ? REG_P2_CTL : REG_P1_CTL,
					8'h87 | ($urandom_range(0, 1) << 6));
			end
			2: begin
				send(ACT_WRITE, REG_W_DAC, 8'h80 | $urandom_range(0, 127));
				send(ACT_WRITE, REG_W_VOL, $urandom_range(0, 255));
				send(ACT_WRITE, REG_W_LEN, $urandom_range(0, 255));
				send(ACT_WRITE, REG_W_FLO, $urandom_range(8'hF0, 8'hFF));
				send(ACT_WRITE, REG_W_CTL, 8'h87 | ($urandom_range(0, 1) << 6));
			end
			default: begin
				send(ACT_WRITE, REG_N_ENV, $urandom_range(8, 255));
				send(ACT_WRITE, REG_N_POLY, $urandom_range(0, 255) & 8'h2F);
				send(ACT_WRITE, REG_N_LEN, $urandom_range(0, 255));
				send(ACT_WRITE, REG_N_CTL, 8'h80 | ($urandom_range(0, 1) << 6));
			end
		endcase
		n = $urandom_range(10, 40);
		for (int i = 0; i < n; i++) random_command();
	endtask

	task automatic random_phase(int upto);
		while (commands_sent < upto) begin
			if ($urandom_range(0, 4) == 0) random_command();
			else play_channel();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		gaps_on = 1;
		stalls_on = 1;
		set_mode(0);
		directed();
		random_phase(200);
		hold_req = 1;
		random_phase(450);
		drain();
		set_mode(1);
		directed();
		random_phase(850);
		drain();
		set_mode(0);
		gaps_on = 0;
		stalls_on = 0;
		random_phase(1150);
		drain();
		$display("Sent %0d commands in both model modes, %0d result beats checked, %0d reads.",
			commands_sent, beats_checked, reads_checked);
		if (errors == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
